// ===== hw/rtl/hwu_pkg.sv =====
// Shared package for the Hebbian weight update block.
// Holds the array sizes, the action codes and the controller/datapath interface structs.
// No dependencies.
package hwu_pkg;

    localparam int NUM_OUTPUTS = 16;
    localparam int NUM_INPUTS  = 16;
    localparam int DATA_W      = 16;
    localparam int MEM_DEPTH   = NUM_OUTPUTS * NUM_INPUTS;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CIDX_W      = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

    typedef enum logic [1:0] {
        ACT_LOAD_X = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_WRITE  = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_x;
        logic write_w;
        logic upd_start;
        logic upd_issue;
        logic rd_issue;
        logic out_load;
    } hwu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_ok;
        logic last_col;
        logic pipe_busy;
        logic out_free;
    } hwu_status_t;

endpackage

// ===== hw/rtl/hwu_ctrl.sv =====
// Controller of the Hebbian weight update block.
// Sequences input words into load, write, row update and read operations.
// Depends on hwu_pkg.
module hwu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  hwu_pkg::hwu_status_t status,
    output hwu_pkg::hwu_cmd_t    cmd
);
    import hwu_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        UPD_ISSUE,
        UPD_DRAIN,
        RD_WAIT
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    action_t act;
    logic    accept;

    assign act      = action_t'(action);
    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        ACT_LOAD_X: cmd.load_x  = 1'b1;
                        ACT_WRITE:  cmd.write_w = 1'b1;
                        ACT_UPDATE:
                        begin
                            // An update of a row outside the matrix does nothing.
                            if (status.row_ok)
                            begin
                                cmd.upd_start = 1'b1;
                                state_next    = UPD_ISSUE;
                            end
                        end
                        ACT_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = RD_WAIT;
                        end
                        default: state_next = IDLE;
                    endcase
                end
            end
            UPD_ISSUE:
            begin
                cmd.upd_issue = 1'b1;
                if (status.last_col)
                begin
                    state_next = UPD_DRAIN;
                end
            end
            UPD_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = IDLE;
                end
            end
            RD_WAIT:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) |-> !status.pipe_busy)
        else $error("update pipeline still busy while controller is idle");

    a_read_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RD_WAIT) |-> !status.pipe_busy)
        else $error("update pipeline busy during a read");

endmodule

// ===== hw/rtl/hwu_datapath.sv =====
// Datapath of the Hebbian weight update block: input vector, weight memory,
// the three-stage read-modify-write update pipeline and the output register.
// Depends on hwu_pkg.
module hwu_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hwu_pkg::hwu_cmd_t           cmd,
    output hwu_pkg::hwu_status_t        status,
    input  logic                        cfg_we,
    input  logic [15:0]                 cfg_wdata,
    input  logic [3:0]                  row,
    input  logic [3:0]                  col,
    input  logic signed [15:0]          value,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic signed [15:0]          weight
);
    import hwu_pkg::*;

    logic [15:0]               decay_reg;
    logic [16:0]               retain;

    logic signed [DATA_W-1:0]  x_reg [NUM_INPUTS];
    logic signed [DATA_W-1:0]  mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]      wvalid_reg;

    logic                      row_ok;
    logic                      col_ok;
    logic [CIDX_W-1:0]         col_idx;
    logic [ADDR_W-1:0]         port_addr;

    logic [ADDR_W-1:0]         base_reg;
    logic [CIDX_W-1:0]         cnt_reg;
    logic signed [DATA_W-1:0]  y_reg;
    logic [ADDR_W-1:0]         upd_addr;

    logic                      mem_re;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0]  wr_data;
    logic signed [DATA_W-1:0]  q_reg;
    logic                      qv_reg;
    logic                      rd_ok_reg;

    logic                      s1_valid_reg;
    logic [ADDR_W-1:0]         s1_addr_reg;
    logic signed [DATA_W-1:0]  x1_reg;
    logic signed [DATA_W-1:0]  w1;
    logic signed [33:0]        kept_prod;
    logic signed [31:0]        learn_prod;

    logic                      s2_valid_reg;
    logic [ADDR_W-1:0]         s2_addr_reg;
    logic signed [17:0]        kept_reg;
    logic signed [23:0]        learn_reg;
    logic signed [24:0]        sum;
    logic signed [DATA_W-1:0]  sum_sat;

    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  weight_reg;

    // Retain factor in Q1.16 lies between one LSB and exactly one.
    assign retain    = 17'(17'h10000 - {1'b0, decay_reg});

    assign row_ok    = (int'(row) < NUM_OUTPUTS);
    assign col_ok    = (int'(col) < NUM_INPUTS);
    assign col_idx   = CIDX_W'(col);
    assign port_addr = ADDR_W'(int'(row) * NUM_INPUTS + int'(col));
    assign upd_addr  = base_reg + ADDR_W'(cnt_reg);

    assign mem_re  = cmd.upd_issue || cmd.rd_issue;
    assign rd_addr = cmd.upd_issue ? upd_addr : port_addr;
    assign mem_we  = s2_valid_reg || (cmd.write_w && row_ok && col_ok);
    assign wr_addr = s2_valid_reg ? s2_addr_reg : port_addr;
    assign wr_data = s2_valid_reg ? sum_sat : value;

    // Entries never written read as zero.
    assign w1         = qv_reg ? q_reg : '0;
    assign kept_prod  = w1 * $signed({1'b0, retain});
    assign learn_prod = y_reg * x1_reg;

    assign sum = {{7{kept_reg[17]}}, kept_reg} + {learn_reg[23], learn_reg};

    always_comb
    begin
        if (sum[24:15] != {10{sum[24]}})
        begin
            sum_sat = sum[24] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            sum_sat = sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_start)
        begin
            base_reg <= ADDR_W'(int'(row) * NUM_INPUTS);
            y_reg    <= value;
        end
        if (cmd.upd_issue)
        begin
            x1_reg      <= x_reg[cnt_reg];
            s1_addr_reg <= upd_addr;
        end
        kept_reg    <= kept_prod[33:16];
        learn_reg   <= learn_prod[31:8];
        s2_addr_reg <= s1_addr_reg;
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= row_ok && col_ok;
        end
        if (cmd.out_load)
        begin
            weight_reg <= (rd_ok_reg && qv_reg) ? q_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= '0;
            wvalid_reg    <= '0;
            qv_reg        <= 1'b0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                x_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                decay_reg <= cfg_wdata;
            end
            if (cmd.load_x && col_ok)
            begin
                x_reg[col_idx] <= value;
            end
            if (mem_we)
            begin
                wvalid_reg[wr_addr] <= 1'b1;
            end
            if (mem_re)
            begin
                qv_reg <= wvalid_reg[rd_addr];
            end
            if (cmd.upd_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.upd_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            s1_valid_reg <= cmd.upd_issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.row_ok    = row_ok;
    assign status.last_col  = (cnt_reg == CIDX_W'(NUM_INPUTS - 1));
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;

    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("update stage one did not advance to stage two");

    a_single_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_issue |-> !(cmd.rd_issue || cmd.write_w || cmd.load_x))
        else $error("memory port shared by an update and another operation");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !cmd.write_w)
        else $error("update write collides with a weight write");

endmodule

// ===== hw/rtl/hebbian_weight_update.sv =====
// Top level of the Hebbian weight update block.
// Joins the controller and the datapath. Depends on hwu_pkg, hwu_ctrl and hwu_datapath.
//
// Usage:
// The input channel (in_valid/in_ready) carries one word of action, row, col and value.
// Action 0 loads input element x[col] and action 3 writes one weight; after either the
// block is ready again in the next cycle. Action 1 updates every column of a
// row, w = (1 - decay) * w + y * x[col], through a three-stage read-modify-write
// pipeline on the weight memory that handles one column per cycle; the block takes
// the next word only once the pipeline has drained. Action 2 reads one weight: it is
// read into the memory read register and then loaded into the output register once that
// is free, where it appears on the output channel (out_valid/out_ready); the block is
// ready for the next word once the output register has been loaded.
// A result waiting in the output register does not hold back loads, writes or updates;
// a second read waits until the output register is taken.
// The user must write the decay fraction register (Q0.16) via cfg_we/cfg_wdata only
// while idle; the block does not enforce this. Reset clears the decay fraction, the
// input vector and all weights (via per-entry valid bits); the block is ready at once.
module hebbian_weight_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] weight,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);
    import hwu_pkg::*;

    hwu_cmd_t    cmd;
    hwu_status_t status;

    hwu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    hwu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .weight    (weight)
    );

endmodule
